### rtl/quadratic_root_solver_defines.svh
// Assertion macros used by the port checker
`ifndef QUADRATIC_ROOT_SOLVER_DEFINES_SVH
`define QUADRATIC_ROOT_SOLVER_DEFINES_SVH
// clocked implication with reset qualifier
`define QRS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication with reset qualifier
`define QRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

### rtl/qrs_pkg.sv
// Package: widths, kind codes and stage payload types of the root solver
package qrs_pkg;
  localparam int CoefW = 16;
  localparam int FracW = 16;
  localparam int OutW = 40;
  localparam int DeltaW = 2 * CoefW + 2;
  localparam int RadW = DeltaW + 2 * FracW;
  localparam int SqW = RadW / 2;
  localparam int NumW = CoefW + FracW + 2 + 1;
  localparam int DenW = CoefW + 1;
  localparam int QW = NumW;

  localparam logic [2:0] KIND_NONE = 3'd0;
  localparam logic [2:0] KIND_ALL = 3'd1;
  localparam logic [2:0] KIND_LINEAR = 3'd2;
  localparam logic [2:0] KIND_DOUBLE = 3'd3;
  localparam logic [2:0] KIND_TWO = 3'd4;

  typedef struct packed {
    logic [2:0] kind;
    logic signed [NumW-1:0] num_one;
    logic signed [NumW-1:0] num_two;
    logic signed [DenW-1:0] den;
  } div_job_t;

  function automatic logic [OutW-1:0] sat_out(input logic signed [QW-1:0] v);
    logic signed [QW-1:0] hi;
    logic signed [QW-1:0] lo;
    hi = QW'(signed'({1'b0, {(OutW-1){1'b1}}}));
    lo = -hi - QW'(1);
    if (QW <= OutW) return OutW'(v);
    if (v > hi) return OutW'(hi);
    if (v < lo) return OutW'(lo);
    return OutW'(v);
  endfunction
endpackage

### rtl/qrs_front.sv
// Front stages: products, discriminant, classification and radicand
module qrs_front (
  input  logic clk,
  input  logic rst_n,
  input  logic adv,
  input  logic in_ok,
  input  logic signed [qrs_pkg::CoefW-1:0] a_i,
  input  logic signed [qrs_pkg::CoefW-1:0] b_i,
  input  logic signed [qrs_pkg::CoefW-1:0] c_i,
  output logic v_o,
  output logic [2:0] kind_o,
  output logic [qrs_pkg::RadW-1:0] rad_o,
  output logic signed [qrs_pkg::NumW-1:0] nb_o,
  output logic signed [qrs_pkg::DenW-1:0] den_o
);
  localparam int DW = qrs_pkg::DeltaW;
  localparam int NW = qrs_pkg::NumW;
  localparam int DNW = qrs_pkg::DenW;

  // stage 1 products
  logic v1_r;
  logic signed [DW-1:0] bb_r, ac4_r;
  logic signed [qrs_pkg::CoefW-1:0] a1_r, b1_r, c1_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (adv) v1_r <= in_ok;
    if (adv) begin
      bb_r <= DW'(b_i) * DW'(b_i);
      ac4_r <= (DW'(a_i) * DW'(c_i)) <<< 2;
      a1_r <= a_i; b1_r <= b_i; c1_r <= c_i;
    end
  end

  // stage 2 classify
  logic signed [DW-1:0] delta;
  logic [2:0] kind;
  logic signed [NW-1:0] nb;
  logic signed [DNW-1:0] den;
  always_comb begin
    delta = bb_r - ac4_r;
    nb = '0;
    den = DNW'(1);
    kind = qrs_pkg::KIND_NONE;
    if (a1_r == '0) begin
      if (b1_r == '0) begin
        kind = (c1_r == '0) ? qrs_pkg::KIND_ALL : qrs_pkg::KIND_NONE;
      end else begin
        kind = qrs_pkg::KIND_LINEAR;
        nb = -(NW'(c1_r) <<< qrs_pkg::FracW);
        den = DNW'(b1_r);
      end
    end else begin
      den = DNW'(a1_r) <<< 1;
      nb = -(NW'(b1_r) <<< qrs_pkg::FracW);
      if (delta < 0) kind = qrs_pkg::KIND_NONE;
      else if (delta == '0) kind = qrs_pkg::KIND_DOUBLE;
      else kind = qrs_pkg::KIND_TWO;
    end
  end

  logic v2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (adv) v2_r <= v1_r;
    if (adv) begin
      kind_o <= kind;
      nb_o <= nb;
      den_o <= den;
      rad_o <= (kind == qrs_pkg::KIND_TWO) ?
               (qrs_pkg::RadW'(unsigned'(delta)) << (2 * qrs_pkg::FracW)) : '0;
    end
  end
  assign v_o = v2_r;
endmodule

### rtl/qrs_sqrt.sv
// Pipelined restoring square root, one result bit per stage
module qrs_sqrt (
  input  logic clk,
  input  logic rst_n,
  input  logic adv,
  input  logic v_i,
  input  logic [2:0] kind_i,
  input  logic [qrs_pkg::RadW-1:0] rad_i,
  input  logic signed [qrs_pkg::NumW-1:0] nb_i,
  input  logic signed [qrs_pkg::DenW-1:0] den_i,
  output logic v_o,
  output qrs_pkg::div_job_t job_o
);
  localparam int RW = qrs_pkg::RadW;
  localparam int SW = qrs_pkg::SqW;
  localparam int NW = qrs_pkg::NumW;

  logic v_r [1:SW];
  logic [2:0] kind_r [1:SW];
  logic [RW-1:0] rem_r [1:SW];
  logic [SW-1:0] root_r [1:SW];
  logic [RW-1:0] src_r [1:SW];
  logic signed [NW-1:0] nb_r [1:SW];
  logic signed [qrs_pkg::DenW-1:0] den_r [1:SW];

  // one stage per root bit, most significant first
  for (genvar k = 0; k < SW; k++) begin : g_bit
    logic v_p;
    logic [2:0] kind_p;
    logic [RW-1:0] rem_p;
    logic [SW-1:0] root_p;
    logic [RW-1:0] src_p;
    logic signed [NW-1:0] nb_p;
    logic signed [qrs_pkg::DenW-1:0] den_p;
    logic [RW+1:0] trial;
    logic [RW+1:0] rem_sh;

    // stage inputs: ports for the first stage, previous registers after
    if (k == 0) begin : g_src
      assign v_p = v_i;
      assign kind_p = kind_i;
      assign rem_p = '0;
      assign root_p = '0;
      assign src_p = rad_i;
      assign nb_p = nb_i;
      assign den_p = den_i;
    end else begin : g_src
      assign v_p = v_r[k];
      assign kind_p = kind_r[k];
      assign rem_p = rem_r[k];
      assign root_p = root_r[k];
      assign src_p = src_r[k];
      assign nb_p = nb_r[k];
      assign den_p = den_r[k];
    end

    always_comb begin
      rem_sh = {rem_p, src_p[RW-1 -: 2]};
      trial = {(RW+2-SW-2)'(0), root_p, 2'b01};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) v_r[k+1] <= 1'b0;
      else if (adv) v_r[k+1] <= v_p;
      if (adv) begin
        kind_r[k+1] <= kind_p;
        nb_r[k+1] <= nb_p;
        den_r[k+1] <= den_p;
        src_r[k+1] <= src_p << 2;
        if (rem_sh >= trial) begin
          rem_r[k+1] <= RW'(rem_sh - trial);
          root_r[k+1] <= {root_p[SW-2:0], 1'b1};
        end else begin
          rem_r[k+1] <= RW'(rem_sh);
          root_r[k+1] <= {root_p[SW-2:0], 1'b0};
        end
      end
    end
  end

  // form numerators for the divide stages
  logic signed [NW-1:0] s_ext;
  always_ff @(posedge clk) begin
    if (!rst_n) v_o <= 1'b0;
    else if (adv) v_o <= v_r[SW];
    if (adv) begin
      job_o.kind <= kind_r[SW];
      job_o.den <= den_r[SW];
      job_o.num_one <= nb_r[SW] + s_ext;
      job_o.num_two <= nb_r[SW] - s_ext;
    end
  end
  assign s_ext = NW'(root_r[SW]);
endmodule

### rtl/qrs_div.sv
// Pipelined signed divider pair, one quotient bit per stage, truncating
module qrs_div (
  input  logic clk,
  input  logic rst_n,
  input  logic adv,
  input  logic v_i,
  input  qrs_pkg::div_job_t job_i,
  output logic v_o,
  output logic [2:0] kind_o,
  output logic [qrs_pkg::OutW-1:0] one_o,
  output logic [qrs_pkg::OutW-1:0] two_o
);
  localparam int NW = qrs_pkg::NumW;
  localparam int DW = qrs_pkg::DenW;

  // magnitudes and quotient signs
  logic [NW-1:0] m1, m2;
  logic [DW-1:0] md;
  always_comb begin
    m1 = job_i.num_one[NW-1] ? NW'(-job_i.num_one) : NW'(job_i.num_one);
    m2 = job_i.num_two[NW-1] ? NW'(-job_i.num_two) : NW'(job_i.num_two);
    md = job_i.den[DW-1] ? DW'(-job_i.den) : DW'(job_i.den);
  end

  logic v_r [1:NW];
  logic [2:0] kind_r [1:NW];
  logic [NW-1:0] q1_r [1:NW], q2_r [1:NW];
  logic [DW:0] r1_r [1:NW], r2_r [1:NW];
  logic [DW-1:0] d_r [1:NW];
  logic ng1_r [1:NW], ng2_r [1:NW];

  for (genvar k = 0; k < NW; k++) begin : g_bit
    logic v_p;
    logic [2:0] kind_p;
    logic [NW-1:0] q1_p, q2_p;
    logic [DW:0] r1_p, r2_p;
    logic [DW-1:0] d_p;
    logic ng1_p, ng2_p;
    logic [DW+1:0] t1, t2;

    // stage inputs: the job for the first stage, previous registers after
    if (k == 0) begin : g_src
      assign v_p = v_i;
      assign kind_p = job_i.kind;
      assign q1_p = m1;
      assign q2_p = m2;
      assign r1_p = '0;
      assign r2_p = '0;
      assign d_p = md;
      assign ng1_p = job_i.num_one[NW-1] ^ job_i.den[DW-1];
      assign ng2_p = job_i.num_two[NW-1] ^ job_i.den[DW-1];
    end else begin : g_src
      assign v_p = v_r[k];
      assign kind_p = kind_r[k];
      assign q1_p = q1_r[k];
      assign q2_p = q2_r[k];
      assign r1_p = r1_r[k];
      assign r2_p = r2_r[k];
      assign d_p = d_r[k];
      assign ng1_p = ng1_r[k];
      assign ng2_p = ng2_r[k];
    end

    always_comb begin
      t1 = {r1_p, q1_p[NW-1]};
      t2 = {r2_p, q2_p[NW-1]};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) v_r[k+1] <= 1'b0;
      else if (adv) v_r[k+1] <= v_p;
      if (adv) begin
        kind_r[k+1] <= kind_p;
        d_r[k+1] <= d_p;
        ng1_r[k+1] <= ng1_p;
        ng2_r[k+1] <= ng2_p;
        if (t1 >= {1'b0, d_p}) begin
          r1_r[k+1] <= (DW+1)'(t1 - {1'b0, d_p});
          q1_r[k+1] <= {q1_p[NW-2:0], 1'b1};
        end else begin
          r1_r[k+1] <= (DW+1)'(t1);
          q1_r[k+1] <= {q1_p[NW-2:0], 1'b0};
        end
        if (t2 >= {1'b0, d_p}) begin
          r2_r[k+1] <= (DW+1)'(t2 - {1'b0, d_p});
          q2_r[k+1] <= {q2_p[NW-2:0], 1'b1};
        end else begin
          r2_r[k+1] <= (DW+1)'(t2);
          q2_r[k+1] <= {q2_p[NW-2:0], 1'b0};
        end
      end
    end
  end

  // apply signs, zero absent roots, saturate
  logic signed [NW-1:0] s1, s2;
  logic [2:0] kf;
  always_comb begin
    kf = kind_r[NW];
    s1 = ng1_r[NW] ? -signed'(q1_r[NW]) : signed'(q1_r[NW]);
    s2 = ng2_r[NW] ? -signed'(q2_r[NW]) : signed'(q2_r[NW]);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v_o <= 1'b0;
    else if (adv) v_o <= v_r[NW];
    if (adv) begin
      kind_o <= kf;
      one_o <= (kf == qrs_pkg::KIND_NONE || kf == qrs_pkg::KIND_ALL) ? '0 :
               qrs_pkg::sat_out(s1);
      two_o <= (kf == qrs_pkg::KIND_TWO) ? qrs_pkg::sat_out(s2) : '0;
    end
  end
endmodule

### rtl/quadratic_root_solver.sv
// Top level: real roots of a*x^2 + b*x + c = 0 in fixed point
//
// Input channel in_*: one coefficient set per transfer, tdata holds
// coef_a, coef_b, coef_c (16 bits each, two's complement).
// Output channel out_*: one result per input, tdata holds root_kind (3),
// root_one (40), root_two (40), zero padded to 88 bits.
// Roots are signed with 16 fraction bits, quotients truncate toward zero.
// Throughput: one item per cycle while out_tready does not stall. Pipeline: 2 front stages, 33 square root
// stages plus numerator stage, 35 divide stages plus output stage.
// The pipeline length is set by the bit-serial root and divide chains.
// Reset (rst_n low, synchronous) clears every valid bit; no results remain.
// A stall on out_tready freezes the whole pipeline in place; in_tready is
// high whenever the final stage is empty or being taken.
module quadratic_root_solver (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  logic [47:0] in_tdata,   // coef_a[15:0], coef_b[31:16], coef_c[47:32]
  output logic out_tvalid,
  input  logic out_tready,
  output logic [87:0] out_tdata   // root_kind[2:0], root_one[42:3], root_two[82:43]
);
  localparam int CW = qrs_pkg::CoefW;

  logic adv;
  logic fv;
  logic [2:0] fkind;
  logic [qrs_pkg::RadW-1:0] frad;
  logic signed [qrs_pkg::NumW-1:0] fnb;
  logic signed [qrs_pkg::DenW-1:0] fden;
  logic sv;
  qrs_pkg::div_job_t sjob;
  logic [2:0] okind;
  logic [qrs_pkg::OutW-1:0] oone, otwo;

  assign adv = !out_tvalid || out_tready;
  assign in_tready = adv;

  qrs_front u_front (
    .clk, .rst_n, .adv, .in_ok(in_tvalid),
    .a_i(in_tdata[CW-1:0]), .b_i(in_tdata[2*CW-1:CW]), .c_i(in_tdata[3*CW-1:2*CW]),
    .v_o(fv), .kind_o(fkind), .rad_o(frad), .nb_o(fnb), .den_o(fden)
  );

  qrs_sqrt u_sqrt (
    .clk, .rst_n, .adv, .v_i(fv), .kind_i(fkind), .rad_i(frad),
    .nb_i(fnb), .den_i(fden), .v_o(sv), .job_o(sjob)
  );

  qrs_div u_div (
    .clk, .rst_n, .adv, .v_i(sv), .job_i(sjob),
    .v_o(out_tvalid), .kind_o(okind), .one_o(oone), .two_o(otwo)
  );

  assign out_tdata = {5'b0, otwo, oone, okind};
endmodule

### rtl/qrs_checker.sv
// Port checker for the root solver, bound to the top level
`include "quadratic_root_solver_defines.svh"
module qrs_checker (
  input logic clk,
  input logic rst_n,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready,
  input logic [87:0] out_tdata
);
  logic [2:0] out_kind;
  logic [79:0] roots;
  logic stall;
  logic kind_ok;
  logic no_root;

  // views of the result transfer
  assign out_kind = out_tdata[2:0];
  assign roots = out_tdata[82:3];
  assign stall = out_tvalid && !out_tready;
  assign kind_ok = (out_kind <= qrs_pkg::KIND_TWO);
  assign no_root = (out_kind == qrs_pkg::KIND_NONE) || (out_kind == qrs_pkg::KIND_ALL);

  `QRS_ASSERT_NEXT(a_hold, clk, rst_n, stall, out_tvalid && $stable(out_tdata), "unstable result")
  `QRS_ASSERT_IMP(a_kind, clk, rst_n, out_tvalid, kind_ok, "bad root kind")
  `QRS_ASSERT_IMP(a_absent, clk, rst_n, out_tvalid && no_root, roots == '0, "absent root not zero")
  `QRS_ASSERT_IMP(a_ready, clk, rst_n, stall, !in_tready, "input taken during stall")
endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (
  .clk, .rst_n, .in_tready, .out_tvalid, .out_tready, .out_tdata
);
